FILE: rtl/core/clv_pkg.sv
package clv_pkg;

    // Fixed field widths of the two channels
    localparam int FUNC_WIDTH  = 3;
    localparam int DATA_WIDTH  = 32;
    localparam int INDEX_WIDTH = 4;
    localparam int COUNT_WIDTH = 5;

    // Operation codes
    localparam logic [FUNC_WIDTH-1:0] FUNC_APPEND        = 3'd0;
    localparam logic [FUNC_WIDTH-1:0] FUNC_APPEND_UNIQUE = 3'd1;
    localparam logic [FUNC_WIDTH-1:0] FUNC_EXISTS        = 3'd2;
    localparam logic [FUNC_WIDTH-1:0] FUNC_GET           = 3'd3;
    localparam logic [FUNC_WIDTH-1:0] FUNC_REMOVE        = 3'd4;

    typedef struct packed {
        logic [FUNC_WIDTH-1:0]  func;
        logic [DATA_WIDTH-1:0]  value;
        logic [INDEX_WIDTH-1:0] index;
    } clv_in_t;

    typedef struct packed {
        logic                   ok;
        logic                   full_res;
        logic [DATA_WIDTH-1:0]  read_value;
        logic [COUNT_WIDTH-1:0] count;
    } clv_out_t;

    // Controller to datapath
    typedef struct packed {
        logic start;        // latch the incoming transaction, clear result
        logic do_append;    // store value at the end if there is room
        logic scan_start;   // rewind the sweep pointer to slot 0
        logic scan_step;    // issue one compare read
        logic set_ok;       // flag success
        logic shift_start;  // start shifting down from the matched slot
        logic shift_step;   // one read/write of the shift sweep
        logic remove_done;  // drop the last slot, flag success
        logic get_issue;    // read the indexed slot
        logic get_capture;  // take the indexed read data
        logic load_out;     // move the result into the output register
    } clv_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [FUNC_WIDTH-1:0] func;
        logic                  hit;        // compare data matches value
        logic                  sweep_end;  // nothing in flight, pointer past the end
        logic                  out_free;   // output register can take a result
    } clv_sts_t;

endpackage

FILE: rtl/core/clv_ctrl.sv
module clv_ctrl
    import clv_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  clv_sts_t sts,
    output clv_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_GET   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (sts.func)
                    FUNC_APPEND: begin
                        cmd.do_append = 1'b1;
                        state_next    = ST_DONE;
                    end
                    FUNC_APPEND_UNIQUE, FUNC_EXISTS, FUNC_REMOVE: begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    FUNC_GET: begin
                        cmd.get_issue = 1'b1;
                        state_next    = ST_GET;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCAN: begin
                if (sts.hit) begin
                    if (sts.func == FUNC_REMOVE) begin
                        cmd.shift_start = 1'b1;
                        state_next      = ST_SHIFT;
                    end else begin
                        // exists reports success, append unique drops the value
                        cmd.set_ok = (sts.func == FUNC_EXISTS);
                        state_next = ST_DONE;
                    end
                end else if (sts.sweep_end) begin
                    cmd.do_append = (sts.func == FUNC_APPEND_UNIQUE);
                    state_next    = ST_DONE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_SHIFT: begin
                if (sts.sweep_end) begin
                    cmd.remove_done = 1'b1;
                    state_next      = ST_DONE;
                end else begin
                    cmd.shift_step = 1'b1;
                end
            end
            ST_GET: begin
                cmd.get_capture = 1'b1;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/clv_dp.sv
module clv_dp
    import clv_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  clv_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output clv_out_t m_data,
    input  clv_cmd_t cmd,
    output clv_sts_t sts
);

    localparam int AW = $clog2(DEPTH);
    localparam int UW = $clog2(DEPTH + 1);
    localparam int CW = (UW > INDEX_WIDTH) ? UW : INDEX_WIDTH;

    // Slot storage
    logic [VALUE_WIDTH-1:0] mem [DEPTH];

    logic [FUNC_WIDTH-1:0]  func_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [INDEX_WIDTH-1:0] index_reg;
    logic [UW-1:0]          used_reg,     used_next;
    logic [UW-1:0]          ptr_reg,      ptr_next;
    logic                   pend_reg,     pend_next;
    logic [AW-1:0]          pend_idx_reg, pend_idx_next;
    logic [VALUE_WIDTH-1:0] rdata_reg;
    logic                   res_ok_reg,   res_ok_next;
    logic                   res_full_reg, res_full_next;
    logic [DATA_WIDTH-1:0]  res_rd_reg,   res_rd_next;
    logic                   m_valid_reg,  m_valid_next;
    clv_out_t               m_data_reg;

    logic                   not_full;
    logic                   in_range;
    logic                   ptr_live;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;

    assign not_full = (used_reg < UW'(DEPTH));
    assign in_range = (CW'(index_reg) < CW'(used_reg));
    assign ptr_live = (ptr_reg < used_reg);

    assign sts.func      = func_reg;
    assign sts.hit       = pend_reg && (rdata_reg == value_reg);
    assign sts.sweep_end = !pend_reg && !ptr_live;
    assign sts.out_free  = !m_valid_reg || m_ready;

    // Memory port control
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = ptr_reg[AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = used_reg[AW-1:0];
        mem_wdata = value_reg;
        if (cmd.do_append && not_full) begin
            mem_we = 1'b1;
        end
        if ((cmd.scan_step || cmd.shift_step) && ptr_live) begin
            mem_re = 1'b1;
        end
        // shift: the slot read last cycle moves down by one
        if (cmd.shift_step && pend_reg) begin
            mem_we    = 1'b1;
            mem_waddr = pend_idx_reg - 1'b1;
            mem_wdata = rdata_reg;
        end
        if (cmd.get_issue) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(index_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Sweep pointer, list length and result
    always_comb begin
        used_next     = used_reg;
        ptr_next      = ptr_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        res_ok_next   = res_ok_reg;
        res_full_next = res_full_reg;
        res_rd_next   = res_rd_reg;
        m_valid_next  = m_valid_reg;

        if (cmd.start) begin
            res_ok_next   = 1'b0;
            res_full_next = 1'b0;
            res_rd_next   = '0;
        end
        if (cmd.do_append) begin
            res_ok_next   = not_full;
            res_full_next = !not_full;
            if (not_full) begin
                used_next = used_reg + 1'b1;
            end
        end
        if (cmd.scan_start) begin
            ptr_next  = '0;
            pend_next = 1'b0;
        end
        if (cmd.scan_step || cmd.shift_step) begin
            pend_next = ptr_live;
            if (ptr_live) begin
                pend_idx_next = ptr_reg[AW-1:0];
                ptr_next      = ptr_reg + 1'b1;
            end
        end
        if (cmd.shift_start) begin
            ptr_next  = UW'(pend_idx_reg) + 1'b1;
            pend_next = 1'b0;
        end
        if (cmd.set_ok) begin
            res_ok_next = 1'b1;
        end
        if (cmd.remove_done) begin
            used_next   = used_reg - 1'b1;
            res_ok_next = 1'b1;
        end
        if (cmd.get_capture) begin
            res_ok_next = in_range;
            res_rd_next = in_range ? DATA_WIDTH'(rdata_reg) : '0;
        end

        // Output register
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            used_reg    <= used_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg      <= ptr_next;
        pend_idx_reg <= pend_idx_next;
        res_ok_reg   <= res_ok_next;
        res_full_reg <= res_full_next;
        res_rd_reg   <= res_rd_next;
        if (cmd.start) begin
            func_reg  <= s_data.func;
            value_reg <= VALUE_WIDTH'(s_data.value);
            index_reg <= s_data.index;
        end
        if (cmd.load_out) begin
            m_data_reg.ok         <= res_ok_reg;
            m_data_reg.full_res   <= res_full_reg;
            m_data_reg.read_value <= res_rd_reg;
            m_data_reg.count      <= COUNT_WIDTH'(used_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= UW'(DEPTH))
        else $error("list length past capacity");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_append && not_full |=> used_reg == $past(used_reg) + 1'b1)
        else $error("append did not grow the list");

    a_remove_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.remove_done |-> used_reg != '0)
        else $error("remove on an empty list");

    a_shift_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift_step && pend_reg |-> pend_idx_reg != '0)
        else $error("shift would write below slot 0");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a pending transaction");

endmodule

FILE: rtl/core/compacting_value_list.sv
// Ordered list of up to DEPTH values of VALUE_WIDTH bits, packed from slot 0, one
// transaction at a time. Exists, append unique and remove compare the stored entries
// one per cycle through the single read port of the slot memory; a remove then shifts
// the later entries down one per cycle. A finished result sits in an output register,
// so the next transaction is accepted while it waits.
module compacting_value_list
    import clv_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  clv_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output clv_out_t m_data
);

    clv_cmd_t cmd;
    clv_sts_t sts;

    clv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    clv_dp #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule
